[design/bres_pkg.sv]
// Shared types, widths and codes for the bilinear resampler.
// Used by bres_ctrl, bres_dp and bilinear_resampler; no dependencies.
package bres_pkg;

    // Source image limits and sample width
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int SAMPLE_BITS = 16;

    // Fixed field widths
    localparam int DIM_BITS   = 9;   // src_width / src_height registers
    localparam int SCALE_BITS = 28;  // Q8.20 step registers
    localparam int COORD_BITS = 12;  // destination coordinates
    localparam int IDX_BITS   = 16;  // raster index, store depth 2**IDX_BITS
    localparam int PIX_BITS   = 16;  // result sample
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = SCALE_BITS;

    // Derived widths
    localparam int FRAC_BITS = 20;
    localparam int PROD_BITS = COORD_BITS + SCALE_BITS;      // scaled coordinate
    localparam int INT_BITS  = PROD_BITS - FRAC_BITS;        // integer part
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
    localparam int WID_BITS  = COL_BITS + 1;                 // holds MAX_WIDTH
    localparam int LIN_BITS  = (ROW_BITS + WID_BITS + 1 > IDX_BITS) ?
                               (ROW_BITS + WID_BITS + 1) : IDX_BITS;
    localparam int IMG_DEPTH = 1 << IDX_BITS;
    localparam int TOP_BITS  = SAMPLE_BITS + FRAC_BITS;      // one-axis blend
    localparam int DIFF_BITS = TOP_BITS + 1;                 // signed bot - top
    localparam int LO_BITS   = DIFF_BITS / 2;
    localparam int HI_BITS   = DIFF_BITS - LO_BITS;
    localparam int ACC_BITS  = TOP_BITS + FRAC_BITS + 3;     // signed accumulator

    // Input item kinds (tuser)
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_X    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_Y    = 2'd3;

    // Corner fetched from the image store
    typedef enum logic [1:0] {
        CORNER_A,   // near row, near column
        CORNER_B,   // near row, far column
        CORNER_C,   // far row, near column
        CORNER_D    // far row, far column
    } t_corner;

    // Controller to datapath commands
    typedef struct packed {
        logic    wr;         // write sample from the accepted item
        logic    load_q;     // latch query coordinates
        logic    scale;      // coordinate times step
        logic    clamp;      // corner indices and fractions
        logic    rows;       // row offsets
        t_corner corner;     // store read address select
        logic    cap_a;      // capture near-near sample
        logic    cap_c;      // capture far-near sample
        logic    horz_top;   // blend near row
        logic    horz_bot;   // blend far row
        logic    vdiff;      // far row minus near row
        logic    vlo;        // vertical blend, low partial product
        logic    vhi;        // vertical blend, high partial product
        logic    out_load;   // load result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;      // result register can take a new item
    } t_dp_sts;

endpackage

[design/bres_ctrl.sv]
// Sequencer for the bilinear resampler: accepts items, steps a query
// through scaling, clamping, four store reads and the blend. Uses bres_pkg.
module bres_ctrl
    import bres_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_kind,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CLAMP,
        ST_ROWS,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_RD_D,
        ST_HBOT,
        ST_VDIFF,
        ST_VLO,
        ST_VHI,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.corner = CORNER_A;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_QUERY) begin
                        o_cmd.load_q = 1'b1;
                        n_state      = ST_SCALE;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = ST_ROWS;
            end
            ST_ROWS: begin
                o_cmd.rows = 1'b1;
                n_state    = ST_RD_A;
            end
            ST_RD_A: begin
                o_cmd.corner = CORNER_A;
                n_state      = ST_RD_B;
            end
            ST_RD_B: begin
                // near-near sample is on the read port now
                o_cmd.corner = CORNER_B;
                o_cmd.cap_a  = 1'b1;
                n_state      = ST_RD_C;
            end
            ST_RD_C: begin
                // near-far sample on the read port
                o_cmd.corner   = CORNER_C;
                o_cmd.horz_top = 1'b1;
                n_state        = ST_RD_D;
            end
            ST_RD_D: begin
                o_cmd.corner = CORNER_D;
                o_cmd.cap_c  = 1'b1;
                n_state      = ST_HBOT;
            end
            ST_HBOT: begin
                o_cmd.horz_bot = 1'b1;
                n_state        = ST_VDIFF;
            end
            ST_VDIFF: begin
                o_cmd.vdiff = 1'b1;
                n_state     = ST_VLO;
            end
            ST_VLO: begin
                o_cmd.vlo = 1'b1;
                n_state   = ST_VHI;
            end
            ST_VHI: begin
                o_cmd.vhi = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // hold until the result register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/bres_dp.sv]
// Datapath for the bilinear resampler: configuration registers, image store,
// coordinate scaling, corner addressing, blend arithmetic, result register.
// Uses bres_pkg; driven by bres_ctrl.
module bres_dp
    import bres_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration writes
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // fields of the accepted item
    input  logic [IDX_BITS-1:0]      i_sample_index,
    input  logic [PIX_BITS-1:0]      i_sample_value,
    input  logic [COORD_BITS-1:0]    i_dst_x,
    input  logic [COORD_BITS-1:0]    i_dst_y,
    // control
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    // result channel
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [PIX_BITS-1:0]      o_pixel_value
);

    // Configuration
    logic [DIM_BITS-1:0]   r_src_width;
    logic [DIM_BITS-1:0]   r_src_height;
    logic [SCALE_BITS-1:0] r_scale_x;
    logic [SCALE_BITS-1:0] r_scale_y;

    // Query pipeline registers
    logic [COORD_BITS-1:0] r_qx;
    logic [COORD_BITS-1:0] r_qy;
    logic [PROD_BITS-1:0]  r_cx;
    logic [PROD_BITS-1:0]  r_cy;
    logic [COL_BITS-1:0]   r_x0;
    logic [COL_BITS-1:0]   r_x1;
    logic [ROW_BITS-1:0]   r_y0;
    logic [ROW_BITS-1:0]   r_y1;
    logic [FRAC_BITS-1:0]  r_fx;
    logic [FRAC_BITS-1:0]  r_fy;
    logic [WID_BITS-1:0]   r_w;
    logic [LIN_BITS-1:0]   r_row0;
    logic [LIN_BITS-1:0]   r_row1;
    logic [SAMPLE_BITS-1:0] r_a;
    logic [SAMPLE_BITS-1:0] r_c;
    logic [TOP_BITS-1:0]   r_top;
    logic [TOP_BITS-1:0]   r_bot;
    logic signed [DIFF_BITS-1:0] r_diff;
    logic signed [ACC_BITS-1:0]  r_acc;

    // Image store
    logic [SAMPLE_BITS-1:0] r_mem [IMG_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rdata;

    // Result register
    logic                  r_out_valid;
    logic [PIX_BITS-1:0]   r_pixel;

    // Clamp logic
    logic [WID_BITS-1:0]   w_eff;
    logic [WID_BITS-1:0]   h_eff;
    logic [COL_BITS-1:0]   w_last;
    logic [ROW_BITS-1:0]   h_last;
    logic [INT_BITS-1:0]   x_int;
    logic [INT_BITS-1:0]   y_int;
    logic [COL_BITS-1:0]   x0_c;
    logic [ROW_BITS-1:0]   y0_c;

    // Address and blend logic
    logic [LIN_BITS-1:0]   lin_addr;
    logic [IDX_BITS-1:0]   mem_addr;
    logic [SAMPLE_BITS-1:0] h_near;
    logic signed [SAMPLE_BITS:0]            h_diff;
    logic signed [TOP_BITS+1:0]             h_prod;
    logic signed [TOP_BITS+1:0]             h_sum;
    logic [LO_BITS+FRAC_BITS-1:0]           v_lo_prod;
    logic signed [HI_BITS+FRAC_BITS:0]      v_hi_prod;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DIM_BITS'(256);
            r_src_height <= DIM_BITS'(256);
            r_scale_x    <= SCALE_BITS'(1 << FRAC_BITS);
            r_scale_y    <= SCALE_BITS'(1 << FRAC_BITS);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[DIM_BITS-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[DIM_BITS-1:0];
                CFG_SCALE_X:    r_scale_x    <= i_cfg_data[SCALE_BITS-1:0];
                CFG_SCALE_Y:    r_scale_y    <= i_cfg_data[SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective image size, zero taken as one, capped at the maximum
    always_comb begin
        if (r_src_width == '0) begin
            w_eff = WID_BITS'(1);
        end else if (r_src_width > DIM_BITS'(MAX_WIDTH)) begin
            w_eff = WID_BITS'(MAX_WIDTH);
        end else begin
            w_eff = WID_BITS'(r_src_width);
        end
        if (r_src_height == '0) begin
            h_eff = WID_BITS'(1);
        end else if (r_src_height > DIM_BITS'(MAX_HEIGHT)) begin
            h_eff = WID_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = WID_BITS'(r_src_height);
        end
    end

    assign w_last = COL_BITS'(w_eff - WID_BITS'(1));
    assign h_last = ROW_BITS'(h_eff - WID_BITS'(1));
    assign x_int  = r_cx[PROD_BITS-1:FRAC_BITS];
    assign y_int  = r_cy[PROD_BITS-1:FRAC_BITS];
    assign x0_c   = (x_int > INT_BITS'(w_last)) ? w_last : x_int[COL_BITS-1:0];
    assign y0_c   = (y_int > INT_BITS'(h_last)) ? h_last : y_int[ROW_BITS-1:0];

    // Coordinate, clamp and row-offset stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_q) begin
            r_qx <= i_dst_x;
            r_qy <= i_dst_y;
        end
        if (i_cmd.scale) begin
            r_cx <= PROD_BITS'(r_qx) * PROD_BITS'(r_scale_x);
            r_cy <= PROD_BITS'(r_qy) * PROD_BITS'(r_scale_y);
        end
        if (i_cmd.clamp) begin
            r_x0 <= x0_c;
            r_y0 <= y0_c;
            r_x1 <= (x0_c == w_last) ? w_last : x0_c + COL_BITS'(1);
            r_y1 <= (y0_c == h_last) ? h_last : y0_c + ROW_BITS'(1);
            r_fx <= r_cx[FRAC_BITS-1:0];
            r_fy <= r_cy[FRAC_BITS-1:0];
            r_w  <= w_eff;
        end
        if (i_cmd.rows) begin
            r_row0 <= LIN_BITS'(r_y0) * LIN_BITS'(r_w);
            r_row1 <= LIN_BITS'(r_y1) * LIN_BITS'(r_w);
        end
    end

    // Corner address
    always_comb begin
        case (i_cmd.corner)
            CORNER_A: lin_addr = r_row0 + LIN_BITS'(r_x0);
            CORNER_B: lin_addr = r_row0 + LIN_BITS'(r_x1);
            CORNER_C: lin_addr = r_row1 + LIN_BITS'(r_x0);
            CORNER_D: lin_addr = r_row1 + LIN_BITS'(r_x1);
            default:  lin_addr = r_row0 + LIN_BITS'(r_x0);
        endcase
    end

    assign mem_addr = i_cmd.wr ? i_sample_index : lin_addr[IDX_BITS-1:0];

    // Single-port image store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[mem_addr] <= i_sample_value[SAMPLE_BITS-1:0];
        end
        r_rdata <= r_mem[mem_addr];
    end

    // Horizontal blend: near + (far - near) * fx, shared by both rows
    assign h_near = i_cmd.horz_top ? r_a : r_c;
    assign h_diff = $signed({1'b0, r_rdata}) - $signed({1'b0, h_near});
    assign h_prod = h_diff * $signed({1'b0, r_fx});
    assign h_sum  = $signed({2'b00, h_near, {FRAC_BITS{1'b0}}}) + h_prod;

    // Vertical blend partial products over the low and high halves of the difference
    assign v_lo_prod = r_diff[LO_BITS-1:0] * r_fy;
    assign v_hi_prod = $signed(r_diff[DIFF_BITS-1:LO_BITS]) * $signed({1'b0, r_fy});

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_a <= r_rdata;
        end
        if (i_cmd.cap_c) begin
            r_c <= r_rdata;
        end
        if (i_cmd.horz_top) begin
            r_top <= h_sum[TOP_BITS-1:0];
        end
        if (i_cmd.horz_bot) begin
            r_bot <= h_sum[TOP_BITS-1:0];
        end
        if (i_cmd.vdiff) begin
            r_diff <= $signed({1'b0, r_bot}) - $signed({1'b0, r_top});
        end
        if (i_cmd.vlo) begin
            r_acc <= $signed({{(ACC_BITS-TOP_BITS-FRAC_BITS){1'b0}}, r_top,
                              {FRAC_BITS{1'b0}}})
                   + $signed(ACC_BITS'(v_lo_prod));
        end else if (i_cmd.vhi) begin
            r_acc <= r_acc + $signed({v_hi_prod[HI_BITS+FRAC_BITS], v_hi_prod,
                                      {LO_BITS{1'b0}}});
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pixel <= PIX_BITS'(r_acc[2*FRAC_BITS +: SAMPLE_BITS]);
        end
    end

    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_pixel_value  = r_pixel;

endmodule

[design/bilinear_resampler.sv]
// Bilinear resampler with align-corners mapping. A write item (tuser 0) stores
// one sample into a 64K-entry image store. A query item
// (tuser 1) scales its destination column and row by the Q8.20 step
// registers, clamps the corners to the last column and row in use, fetches
// the four corner samples one per cycle from the single-port image store and
// blends them horizontally, then vertically, truncating the result. A query
// holds off the input from its acceptance through the four store
// reads plus the scale, clamp, row-offset and blend steps of the shared
// multipliers, and longer while an earlier result still waits in the output
// register; the next item is taken while the result still waits on the
// output register. Configuration registers: 0 src_width, 1 src_height,
// 2 scale_x, 3 scale_y; write them only while the block is idle. Image store
// contents are undefined until written.
// Depends on bres_pkg, bres_ctrl and bres_dp.
module bilinear_resampler
    import bres_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input items
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [55:0]              i_s_tdata,  // sample_index[15:0], sample_value[31:16],
                                                 // dst_x[43:32], dst_y[55:44]
    input  logic                     i_s_tuser,  // kind[0]
    // result items
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [PIX_BITS-1:0]      o_m_tdata,  // pixel_value[15:0]
    // configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    bres_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bres_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_index (i_s_tdata[15:0]),
        .i_sample_value (i_s_tdata[31:16]),
        .i_dst_x        (i_s_tdata[43:32]),
        .i_dst_y        (i_s_tdata[55:44]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_pixel_value  (o_m_tdata)
    );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for bilinear_resampler: image writes and pixel queries under
// several size and step settings, each result checked against an in-bench predictor.
// Depends on bres_pkg and the bilinear_resampler RTL.
module testbench;
    import bres_pkg::*;

    localparam int SETTLE_CYCLES = 32;     // covers a query in flight plus the output register
    localparam int RANDOM_ITEMS  = 1800;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 400;

    // One input item, unpacked for the generator and the predictor
    typedef struct packed {
        logic        kind;
        logic [11:0] row;
        logic [11:0] col;
        logic [15:0] value;
        logic [15:0] index;
    } t_raster_item;

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic [55:0]              s_tdata   = '0;
    logic                     s_tuser   = 1'b0;
    logic                     m_tready  = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     o_s_tready;
    logic                     o_m_tvalid;
    logic [PIX_BITS-1:0]      o_m_tdata;
    logic                     o_cfg_ready;

    // Pending items and predicted pixels
    t_raster_item  raster_items[$];
    logic [15:0]   expected_pixels[$];
    t_raster_item  on_bus;

    // Predictor state, updated at handshakes
    logic [15:0]   img_shadow [IMG_DEPTH];
    logic [8:0]    cfg_w, cfg_h;
    logic [27:0]   cfg_sx, cfg_sy;

    // Generator view: settings it has planned and entries it has scheduled a write for
    bit            planned_written [IMG_DEPTH];
    logic [8:0]    plan_w = 9'd256;
    logic [8:0]    plan_h = 9'd256;
    logic [27:0]   plan_sx = 28'd1 << FRAC_BITS;
    logic [27:0]   plan_sy = 28'd1 << FRAC_BITS;

    int unsigned   items_pushed = 0;
    int unsigned   mismatches = 0;
    int unsigned   results_seen = 0;

    bilinear_resampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Corner addresses and fractions of a query; sizes saturate, far corners clamp
    function automatic void corner_map(input logic [11:0] col, row,
                                       input logic [8:0] w_reg, h_reg,
                                       input logic [27:0] sx, sy,
                                       output logic [3:0][15:0] addr,
                                       output logic [19:0] fx, fy);
        logic [39:0] cx, cy;
        int unsigned w, h, x0, y0, x1, y1;
        w  = (w_reg == 0) ? 1 : (w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg;
        h  = (h_reg == 0) ? 1 : (h_reg > MAX_HEIGHT) ? MAX_HEIGHT : h_reg;
        cx = 40'(col) * 40'(sx);
        cy = 40'(row) * 40'(sy);
        fx = cx[19:0];
        fy = cy[19:0];
        x0 = cx[39:20];
        y0 = cy[39:20];
        if (x0 > w - 1) x0 = w - 1;
        if (y0 > h - 1) y0 = h - 1;
        x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
        y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
        addr[CORNER_A] = 16'(y0 * w + x0);
        addr[CORNER_B] = 16'(y0 * w + x1);
        addr[CORNER_C] = 16'(y1 * w + x0);
        addr[CORNER_D] = 16'(y1 * w + x1);
    endfunction

    // Exact two-pass blend, truncated
    function automatic logic [15:0] interp_pixel(input logic [11:0] col, row);
        logic [3:0][15:0] addr;
        logic [19:0]      fx, fy;
        longint unsigned  one, top, bot, acc;
        corner_map(col, row, cfg_w, cfg_h, cfg_sx, cfg_sy, addr, fx, fy);
        one = 64'd1 << FRAC_BITS;
        top = img_shadow[addr[CORNER_A]] * (one - fx) + img_shadow[addr[CORNER_B]] * fx;
        bot = img_shadow[addr[CORNER_C]] * (one - fx) + img_shadow[addr[CORNER_D]] * fx;
        acc = (top * (one - fy) + bot * fy) >> (2 * FRAC_BITS);
        return acc[15:0];
    endfunction

    function automatic void push_write(input logic [15:0] index, value);
        t_raster_item it;
        it.kind  = KIND_WRITE;
        it.index = index;
        it.value = value;
        it.col   = 12'($urandom);
        it.row   = 12'($urandom);
        raster_items.insert(raster_items.size(), it);
        planned_written[index] = 1'b1;
        items_pushed++;
    endfunction

    // A query first gets writes for any corner not yet stored
    function automatic void push_query(input logic [11:0] col, row);
        t_raster_item     it;
        logic [3:0][15:0] addr;
        logic [19:0]      fx, fy;
        corner_map(col, row, plan_w, plan_h, plan_sx, plan_sy, addr, fx, fy);
        for (int k = 0; k < 4; k++) begin
            if (!planned_written[addr[k]]) push_write(addr[k], 16'($urandom));
        end
        it.kind  = KIND_QUERY;
        it.index = 16'($urandom);
        it.value = 16'($urandom);
        it.col   = col;
        it.row   = row;
        raster_items.insert(raster_items.size(), it);
        items_pushed++;
    endfunction

    // Wait until nothing is queued or outstanding, then let the block settle
    task automatic wait_drained();
        do @(posedge i_clk);
        while (raster_items.size() != 0 || s_tvalid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back; valid stays high between writes
    task automatic program_regs(input logic [8:0] w_reg, h_reg, input logic [27:0] sx, sy);
        logic [CFG_IDX_BITS-1:0]  regs [4];
        logic [CFG_DATA_BITS-1:0] vals [4];
        regs = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_SCALE_X, CFG_SCALE_Y};
        vals = '{CFG_DATA_BITS'(w_reg), CFG_DATA_BITS'(h_reg), sx, sy};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            do @(posedge i_clk);
            while (!o_cfg_ready);
        end
        cfg_valid <= 1'b0;
        plan_w  = w_reg;
        plan_h  = h_reg;
        plan_sx = sx;
        plan_sy = sy;
    endtask

    // Stimulus: directed checks, then random phases with their own settings
    initial begin
        logic [8:0]  w_reg, h_reg;
        logic [27:0] sx, sy;
        int unsigned eff_w, eff_h, dst_w, dst_h, n_items, pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: 256x256, unit step; image extremes and saturated coordinates
        push_write(16'h0000, 16'h0000);
        push_write(16'hFFFF, 16'hFFFF);
        push_query(12'd0, 12'd0);
        push_query(12'd255, 12'd255);
        push_query(12'hFFF, 12'hFFF);
        push_query(12'hFFF, 12'd0);
        push_query(12'd0, 12'hFFF);
        wait_drained();

        // 2x2 image, half step across, just under unit step down
        program_regs(9'd2, 9'd2, 28'h0080000, 28'h00FFFFF);
        push_write(16'd0, 16'hFFFF);
        push_write(16'd1, 16'h0000);
        push_write(16'd2, 16'h0000);
        push_write(16'd3, 16'hFFFF);
        push_query(12'd1, 12'd0);
        push_query(12'd1, 12'd1);
        push_query(12'd2, 12'd1);
        push_query(12'd3, 12'd3);
        wait_drained();

        // Sizes out of range (zero width, all-ones height), zero and all-ones steps
        program_regs(9'd0, 9'h1FF, 28'd0, 28'hFFFFFFF);
        push_query(12'hFFF, 12'd1);
        push_query(12'd0, 12'd0);
        push_query(12'd5, 12'd3);
        wait_drained();

        items_pushed = 0;
        while (items_pushed < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                w_reg = 9'($urandom);
                h_reg = 9'($urandom);
            end else if (pick == 1) begin
                w_reg = $urandom_range(0, 1) ? 9'd256 : 9'd1;
                h_reg = $urandom_range(0, 1) ? 9'd256 : 9'd1;
            end else begin
                w_reg = 9'($urandom_range(1, 12));
                h_reg = 9'($urandom_range(1, 12));
            end
            eff_w = (w_reg == 0) ? 1 : (w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg;
            eff_h = (h_reg == 0) ? 1 : (h_reg > MAX_HEIGHT) ? MAX_HEIGHT : h_reg;
            dst_w = $urandom_range(1, 24);
            dst_h = $urandom_range(1, 24);

            // Mostly align-corners steps; sometimes arbitrary or extreme ones
            sx = (dst_w > 1) ? 28'(((eff_w - 1) << FRAC_BITS) / (dst_w - 1)) : 28'd0;
            sy = (dst_h > 1) ? 28'(((eff_h - 1) << FRAC_BITS) / (dst_h - 1)) : 28'd0;
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                sx = 28'($urandom);
                sy = 28'($urandom);
            end else if (pick == 2) begin
                sx = 28'hFFFFFFF;
                sy = 28'd267386880;
            end else if (pick == 3) begin
                sx = 28'd267386880;
                sy = 28'd0;
            end
            program_regs(w_reg, h_reg, sx, sy);

            // Small images get a full raster load first, if it fits the item budget
            if (eff_w * eff_h <= 256 && items_pushed + eff_w * eff_h <= RANDOM_ITEMS) begin
                for (int i = 0; i < eff_w * eff_h; i++) push_write(16'(i), 16'($urandom));
            end

            n_items = $urandom_range(60, 160);
            for (int i = 0; i < n_items && items_pushed < RANDOM_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 72)
                    push_query(12'($urandom_range(0, dst_w - 1)),
                               12'($urandom_range(0, dst_h - 1)));
                else if (pick < 82)
                    push_query(12'($urandom), 12'($urandom));
                else if (pick < 92)
                    push_write(16'($urandom_range(0, eff_w * eff_h - 1)), 16'($urandom));
                else
                    push_write(16'($urandom), 16'($urandom));
            end
            wait_drained();
        end

        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(64'd8_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // Driver: bursts with random gaps; prediction happens at each accepted item
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                if (on_bus.kind == KIND_WRITE)
                    img_shadow[on_bus.index] = on_bus.value;
                else
                    expected_pixels.insert(expected_pixels.size(),
                                           interp_pixel(on_bus.col, on_bus.row));
            end
            if (!s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (raster_items.size() > 0) begin
                    on_bus   = raster_items.pop_front();
                    s_tdata  <= {on_bus.row, on_bus.col, on_bus.value, on_bus.index};
                    s_tuser  <= on_bus.kind;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(40, 200);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left   = $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Register shadow for the predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_w  <= 9'd256;
            cfg_h  <= 9'd256;
            cfg_sx <= 28'd1 << FRAC_BITS;
            cfg_sy <= 28'd1 << FRAC_BITS;
        end else if (cfg_valid && o_cfg_ready) begin
            case (cfg_index)
                CFG_SRC_WIDTH:  cfg_w  <= cfg_data[8:0];
                CFG_SRC_HEIGHT: cfg_h  <= cfg_data[8:0];
                CFG_SCALE_X:    cfg_sx <= cfg_data[27:0];
                CFG_SCALE_Y:    cfg_sy <= cfg_data[27:0];
                default: ;
            endcase
        end
    end

    // Receiver: stall segments of random density, plus one long hold-off while items queue up
    int unsigned hold_left = 0;
    int unsigned seg_left = 0;
    int unsigned stall_pct = 0;
    bit          held_once = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!held_once && results_seen >= 30 && raster_items.size() > 40) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 150);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor: each result against the oldest prediction
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (expected_pixels.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("[%0t] pixel_value %0d arrived with none expected", $time, o_m_tdata);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_m_tdata !== want) begin
                    if (mismatches < MAX_REPORTS)
                        $display("[%0t] pixel_value expected %0d got %0d",
                                 $time, want, o_m_tdata);
                    mismatches++;
                end
            end
        end
    end

endmodule
